// ===== rtl/core/rsi_pkg.sv =====
// Package for the row shear interpolator: field widths, codes and the
// command bundle from the controller to the datapath.
// No dependencies.

package rsi_pkg;

	// fixed field widths
	localparam int FUNC_W     = 1;
	localparam int COLUMN_W   = 12;
	localparam int ROW_W      = 12;
	localparam int PIX_W      = 8;
	localparam int COEFF_W    = 18;
	localparam int RWIDTH_W   = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 18;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SHEAR_COEFF = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'b1;

	// reset values of the registers
	localparam logic signed [COEFF_W-1:0] SHEAR_COEFF_RST = '0;
	localparam logic [RWIDTH_W-1:0]       ROW_WIDTH_RST   = 13'd4096;

	// item function codes
	localparam logic [FUNC_W-1:0] FUNC_STORE   = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_PRODUCE = 1'b1;

	// pixel value reported for a source position off the row
	localparam logic [PIX_W-1:0] PIX_OUTSIDE = 8'd255;

	// smallest usable row width
	localparam int MIN_ROW_WIDTH = 2;

	// controller to datapath commands
	typedef struct packed {
		logic store_wr;  // write pixel_in into the row store
		logic prod_ld;   // capture column and row*coeff
		logic pos_calc;  // form source position and range check
		logic rd_lo;     // read left neighbor x0
		logic rd_hi;     // read right neighbor x0+1, keep left
		logic out_ld;    // load the result register
	} rsi_cmd_t;

endpackage

// ===== rtl/core/rsi_in_if.sv =====
// Input item channel of the row shear interpolator.
// Depends on rsi_pkg.

interface rsi_in_if import rsi_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [COLUMN_W-1:0] column;
	logic [ROW_W-1:0]    row;
	logic [PIX_W-1:0]    pixel_in;

	modport source (output valid, output func, output column, output row,
		output pixel_in, input ready);
	modport sink (input valid, input func, input column, input row,
		input pixel_in, output ready);
endinterface

// ===== rtl/core/rsi_out_if.sv =====
// Result channel of the row shear interpolator.
// Depends on rsi_pkg.

interface rsi_out_if import rsi_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             outside;

	modport source (output valid, output pixel_out, output outside, input ready);
	modport sink (input valid, input pixel_out, input outside, output ready);
endinterface

// ===== rtl/core/rsi_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.

module rsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/rsi_ctrl.sv =====
// Controller of the row shear interpolator: item sequencing and result valid.
// Depends on rsi_pkg.

module rsi_ctrl import rsi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [FUNC_W-1:0] in_func,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output rsi_cmd_t          cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_POS  = 5'b00010,
		ST_RD0  = 5'b00100,
		ST_RD1  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   ovalid_q;
	logic   in_beat;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign out_free  = !ovalid_q || out_ready;
	assign out_valid = ovalid_q;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.store_wr = in_beat && (in_func == FUNC_STORE);
		cmd.prod_ld  = in_beat && (in_func == FUNC_PRODUCE);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.prod_ld) begin
					state_d = ST_POS;
				end
			end
			ST_POS: begin
				cmd.pos_calc = 1'b1;
				state_d      = ST_RD0;
			end
			ST_RD0: begin
				cmd.rd_lo = 1'b1;
				state_d   = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd_hi = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid, set on load and cleared when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/rsi_datapath.sv =====
// Datapath of the row shear interpolator: registers, position math,
// row store and linear interpolation.
// Depends on rsi_pkg and rsi_ram.

module rsi_datapath import rsi_pkg::*; #(
	parameter int MAX_WIDTH = 4096,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rsi_cmd_t              cmd,
	input  logic [COLUMN_W-1:0]   column,
	input  logic [ROW_W-1:0]      row,
	input  logic [PIX_W-1:0]      pixel_in,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic [PIX_W-1:0]      pixel_out,
	output logic                  outside
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = ROW_W + 1 + COEFF_W;
	localparam int CW = COLUMN_W + FRAC_BITS + 1;
	localparam int XW = ((PW > CW) ? PW : CW) + 1;
	localparam int SW = PIX_W + FRAC_BITS + 2;

	logic signed [COEFF_W-1:0] coeff_q;
	logic [RWIDTH_W-1:0]       width_q;

	logic signed [PW-1:0]      prod_s1;
	logic [COLUMN_W-1:0]       col_s1;
	logic signed [XW-1:0]      xin;
	logic signed [XW-1:0]      x0_full;
	logic [XW-1:0]             w_raw;
	logic [XW-1:0]             w_eff;
	logic signed [XW-1:0]      w_lim;
	logic                      off_row;
	logic [AW-1:0]             x0_s2;
	logic [FRAC_BITS-1:0]      frac_s2;
	logic                      off_s2;

	logic                      ram_re;
	logic [AW-1:0]             ram_raddr;
	logic [PIX_W-1:0]          ram_rdata;
	logic                      store_ok;
	logic [PIX_W-1:0]          p0_s3;

	logic signed [PIX_W:0]     diff;
	logic signed [SW-1:0]      mix;
	logic signed [SW-1:0]      acc;
	logic [PIX_W-1:0]          interp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= SHEAR_COEFF_RST;
			width_q <= ROW_WIDTH_RST;
		end else if (cfg_we) begin
			if (cfg_idx == REG_SHEAR_COEFF) begin
				coeff_q <= $signed(cfg_wdata[COEFF_W-1:0]);
			end
			if (cfg_idx == REG_ROW_WIDTH) begin
				width_q <= cfg_wdata[RWIDTH_W-1:0];
			end
		end
	end

	// stage 1: row times shear coefficient on the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.prod_ld) begin
			prod_s1 <= PW'($signed({1'b0, row})) * PW'(coeff_q);
			col_s1  <= column;
		end
	end

	// source position, floor and clamped row limit
	assign xin     = $signed(XW'({col_s1, {FRAC_BITS{1'b0}}})) + XW'(prod_s1);
	assign x0_full = xin >>> FRAC_BITS;
	assign w_raw   = XW'(width_q);

	always_comb begin
		priority if (w_raw < XW'(MIN_ROW_WIDTH)) begin
			w_eff = XW'(MIN_ROW_WIDTH);
		end else if (w_raw > XW'(MAX_WIDTH)) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
	end

	assign w_lim   = $signed(w_eff - XW'(1));
	assign off_row = xin[XW-1] || (x0_full >= w_lim);

	// stage 2: position fields
	always_ff @(posedge clk) begin
		if (cmd.pos_calc) begin
			x0_s2   <= x0_full[AW-1:0];
			frac_s2 <= xin[FRAC_BITS-1:0];
			off_s2  <= off_row;
		end
	end

	// row store: writes on store beats with an in-range column, two reads per produce item
	assign store_ok  = (32'(column) < 32'(MAX_WIDTH));
	assign ram_re    = cmd.rd_lo || cmd.rd_hi;
	assign ram_raddr = cmd.rd_hi ? (x0_s2 + AW'(1)) : x0_s2;

	rsi_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_row_store (
		.clk  (clk),
		.we   (cmd.store_wr && store_ok),
		.waddr(AW'(column)),
		.wdata(pixel_in),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// keep left neighbor while the right one is read
	always_ff @(posedge clk) begin
		if (cmd.rd_hi) begin
			p0_s3 <= ram_rdata;
		end
	end

	// p0 + (p1 - p0) * frac, truncated
	assign diff   = $signed({1'b0, ram_rdata}) - $signed({1'b0, p0_s3});
	assign mix    = SW'(diff) * SW'($signed({1'b0, frac_s2}));
	assign acc    = $signed(SW'({p0_s3, {FRAC_BITS{1'b0}}})) + mix;
	assign interp = acc[FRAC_BITS+PIX_W-1:FRAC_BITS];

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			pixel_out <= off_s2 ? PIX_OUTSIDE : interp;
			outside   <= off_s2;
		end
	end

endmodule

// ===== rtl/core/row_shear_interpolator_unit.sv =====
// Top level of the row shear interpolator: controller, datapath, channels.
// Depends on rsi_pkg, rsi_in_if, rsi_out_if, rsi_ctrl and rsi_datapath.
//
//  channel   dir  beat contents
//  item      in   func, column, row, pixel_in
//  result    out  pixel_out, outside
//  cfg       in   cfg_we, cfg_idx, cfg_wdata (shear_coeff, row_width)
//
// a store beat leaves the controller idle; the next beat can follow right after it
// a produce beat goes through multiply, position and range check,
// then two reads of the single read port of the row store and the blend
// the result sits in an output register; a new beat is taken while it waits,
// and a produce beat only stalls in its last cycle if that register is full
// reset clears the control state and the configuration registers; the row
// store is not cleared and holds garbage until written

module row_shear_interpolator_unit import rsi_pkg::*; #(
	parameter int MAX_WIDTH = 4096,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rsi_in_if.sink                item,
	rsi_out_if.source             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	rsi_cmd_t cmd;

	// sequencing
	rsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_func  (item.func),
		.in_ready (item.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.cmd      (cmd)
	);

	// arithmetic and storage
	rsi_datapath #(
		.MAX_WIDTH(MAX_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.column   (item.column),
		.row      (item.row),
		.pixel_in (item.pixel_in),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.pixel_out(result.pixel_out),
		.outside  (result.outside)
	);

endmodule
